// ===== src/aes_ctr_pkg.sv =====
package aes_ctr_pkg;

	localparam int RoundsN = 14;
	localparam int SchedWords = 60;
	localparam int KeyWords = 8;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_EXPAND = 6'b000010,
		ST_LOAD   = 6'b000100,
		ST_ROUND  = 6'b001000,
		ST_XOR    = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		REG_KEY0 = 3'd0,
		REG_KEY1 = 3'd1,
		REG_KEY2 = 3'd2,
		REG_KEY3 = 3'd3,
		REG_IVH  = 3'd4,
		REG_IVL  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic       go;
		logic       start;
		logic [3:0] round;
	} rnd_ctl_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

// ===== src/aes256_ctr_keystream_xor.sv =====
// within a keystream block, an accepted byte passes the XOR and OUT states and is registered to out_byte
// a new block first runs LOAD and ROUND for each of 15 round keys: four schedule words read, then one round
// a restart first expands the key into 60 schedule words, one schedule word written per cycle
// one request in flight: the input stalls until the result is registered, and while OUT waits on out_stall
// reset: asynchronous; the input stalls while the all-zero key is expanded into the schedule
module aes256_ctr_keystream_xor
	import aes_ctr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	state_t st_q;
	logic [63:0] key_q [4];
	logic [63:0] ivh_q, ivl_q;
	logic [127:0] ctr_q;
	logic [127:0] ks_q;
	logic [4:0]  pos_q;
	logic [7:0]  data_q;
	logic [7:0]  out_q;
	logic        ov_q;
	logic        rst_pending_q;
	logic [5:0]  widx_q;
	logic [255:0] win_q;
	logic [7:0]  rcon_q;
	logic [5:0]  ridx_q;
	logic [3:0]  rnd_q;
	logic        rd_live_q;
	logic        we;
	logic [5:0]  waddr;
	logic [31:0] wdata;
	logic [31:0] rdata;
	logic [5:0]  raddr;
	logic [31:0] t;
	logic [31:0] nw;
	logic [127:0] rk_q;
	logic [1:0]  rk_cnt_q;
	rnd_ctl_t    ctl;
	logic [127:0] aes_state;
	logic        accept;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (st_q != ST_IDLE);

	// schedule word generation from a 256-bit window
	always_comb begin
		t = win_q[31:0];
		if (widx_q[2:0] == 3'd0) begin
			t = sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'h0};
		end else if (widx_q[2:0] == 3'd4) begin
			t = sub_word(t);
		end
		nw = win_q[255:224] ^ t;
	end

	always_comb begin
		if (widx_q < 6'(KeyWords)) begin
			wdata = win_q[255 - 32*widx_q[2:0] -: 32];
		end else begin
			wdata = nw;
		end
		we    = (st_q == ST_EXPAND);
		waddr = widx_q;
	end

	assign raddr = ridx_q;

	aes_ctr_ram #(.Width(32), .Depth(64)) u_sched (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign ctl = '{go: (st_q == ST_ROUND), start: (rnd_q == 4'd0), round: rnd_q};

	aes_ctr_round u_round (
		.clk(clk), .ctl(ctl), .init(ctr_q), .rkey(rk_q), .state(aes_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_EXPAND;
			key_q         <= '{default: '0};
			ivh_q         <= '0;
			ivl_q         <= '0;
			ctr_q         <= '0;
			ks_q          <= '0;
			pos_q         <= 5'd16;
			data_q        <= '0;
			out_q         <= '0;
			ov_q          <= 1'b0;
			widx_q        <= '0;
			win_q         <= '0;
			rcon_q        <= 8'h01;
			ridx_q        <= '0;
			rnd_q         <= '0;
			rk_q          <= '0;
			rk_cnt_q      <= '0;
			rd_live_q     <= 1'b0;
			rst_pending_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KEY0: key_q[0] <= cfg_data;
					REG_KEY1: key_q[1] <= cfg_data;
					REG_KEY2: key_q[2] <= cfg_data;
					REG_KEY3: key_q[3] <= cfg_data;
					REG_IVH:  ivh_q    <= cfg_data;
					REG_IVL:  ivl_q    <= cfg_data;
					default: ;
				endcase
			end
			if (st_q == ST_OUT && (!ov_q || !out_stall)) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						data_q <= data_byte;
						if (restart) begin
							ctr_q         <= {ivh_q, ivl_q};
							win_q         <= {key_q[0], key_q[1], key_q[2], key_q[3]};
							widx_q        <= '0;
							rcon_q        <= 8'h01;
							pos_q         <= 5'd16;
							rst_pending_q <= 1'b1;
							st_q          <= ST_EXPAND;
						end else if (pos_q[4]) begin
							ridx_q   <= '0;
							rk_cnt_q <= '0;
							rnd_q    <= '0;
							rd_live_q <= 1'b0;
							st_q     <= ST_LOAD;
						end else begin
							st_q <= ST_XOR;
						end
					end
				end
				ST_EXPAND: begin
					if (widx_q >= 6'(KeyWords)) begin
						win_q <= {win_q[223:0], nw};
						if (widx_q[2:0] == 3'd0) begin
							rcon_q <= xtime(rcon_q);
						end
					end
					widx_q <= widx_q + 6'd1;
					if (widx_q == 6'(SchedWords - 1)) begin
						rst_pending_q <= 1'b0;
						if (rst_pending_q) begin
							ridx_q    <= '0;
							rk_cnt_q  <= '0;
							rnd_q     <= '0;
							rd_live_q <= 1'b0;
							st_q      <= ST_LOAD;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				ST_LOAD: begin
					// gather four schedule words, then run a round
					rd_live_q <= 1'b1;
					if (ridx_q[1:0] != 2'd3 || !rd_live_q) begin
						ridx_q <= ridx_q + 6'd1;
					end
					if (rd_live_q) begin
						rk_q     <= {rk_q[95:0], rdata};
						rk_cnt_q <= rk_cnt_q + 2'd1;
						if (rk_cnt_q == 2'd3) begin
							st_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					if (rnd_q == 4'(RoundsN)) begin
						ks_q   <= 128'h0;
						st_q   <= ST_XOR;
						pos_q  <= '0;
						ctr_q  <= ctr_q + 128'd1;
						rnd_q  <= '0;
					end else begin
						rnd_q     <= rnd_q + 4'd1;
						ridx_q    <= ridx_q + 6'd1;
						rd_live_q <= 1'b0;
						rk_cnt_q  <= '0;
						st_q      <= ST_LOAD;
					end
				end
				ST_XOR: begin
					if (rnd_q == 4'd0 && pos_q == 5'd0 && ks_q == 128'h0) begin
						ks_q <= aes_state;
					end
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!ov_q || !out_stall) begin
						out_q <= data_q ^ ks_q[127 - 8*pos_q[3:0] -: 8];
						pos_q <= pos_q + 5'd1;
						st_q  <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign out_byte  = out_q;

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 5'd16) else $error("byte position out of range");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT && (!ov_q || !out_stall)) |=> out_valid) else $error("lost result");
`endif
endmodule

// ===== src/aes_ctr_ram.sv =====
module aes_ctr_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/aes_ctr_round.sv =====
module aes_ctr_round
	import aes_ctr_pkg::*;
(
	input  logic         clk,
	input  rnd_ctl_t     ctl,
	input  logic [127:0] init,
	input  logic [127:0] rkey,
	output logic [127:0] state
);
	logic [127:0] state_q;
	logic [127:0] ss;
	logic [127:0] mc;
	logic [7:0]   b [16];
	logic [7:0]   a0, a1, a2, a3, al;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			b[i] = state_q[127-8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				ss[127-8*(4*c+j) -: 8] = sbox(b[4*((c+j)%4)+j]);
			end
		end
		mc = ss;
		a0 = '0; a1 = '0; a2 = '0; a3 = '0; al = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = ss[127-32*c -: 8];
			a1 = ss[119-32*c -: 8];
			a2 = ss[111-32*c -: 8];
			a3 = ss[103-32*c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			mc[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			mc[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			mc[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			mc[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			if (ctl.start) begin
				state_q <= init ^ rkey;
			end else if (ctl.round == 4'(RoundsN)) begin
				state_q <= ss ^ rkey;
			end else begin
				state_q <= mc ^ rkey;
			end
		end
	end

	assign state = state_q;
endmodule
